### rtl/core/pche_pkg.sv
// Shared types, constants and command codes for the cubic Hermite evaluator.
// No dependencies; every other file of the block but pche_ram imports this package.
`default_nettype none

package pche_pkg;

  // Default sizes; the top level hands them down as parameters.
  localparam int MAX_KNOTS_DEF     = 256;
  localparam int FRACTION_BITS_DEF = 16;

  // Opcodes of an input beat.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BELOW = 2'd1;
  localparam logic [1:0] ST_ABOVE = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  // Configuration register indexes.
  localparam logic REG_KNOT_COUNT  = 1'b0;
  localparam logic REG_EXTRAPOLATE = 1'b1;

  // Datapath commands issued by the controller.
  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_WRITE    = 4'd1;
  localparam logic [3:0] CMD_LOAD     = 4'd2;
  localparam logic [3:0] CMD_FIRST    = 4'd3;
  localparam logic [3:0] CMD_LAST     = 4'd4;
  localparam logic [3:0] CMD_CHECK    = 4'd5;
  localparam logic [3:0] CMD_SRCH_RD  = 4'd6;
  localparam logic [3:0] CMD_CMP      = 4'd7;
  localparam logic [3:0] CMD_SEG0     = 4'd8;
  localparam logic [3:0] CMD_SEG1     = 4'd9;
  localparam logic [3:0] CMD_SEG2     = 4'd10;
  localparam logic [3:0] CMD_DIVI     = 4'd11;
  localparam logic [3:0] CMD_DIV      = 4'd12;
  localparam logic [3:0] CMD_MUL_GO   = 4'd13;
  localparam logic [3:0] CMD_MUL_TAKE = 4'd14;
  localparam logic [3:0] CMD_FIN      = 4'd15;

  // Index of the last product in the evaluation sequence.
  localparam logic [2:0] MUL_LAST = 3'd7;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  entry_index;
    logic signed [31:0] knot_position;
    logic signed [31:0] knot_value;
    logic signed [31:0] knot_slope;
    logic signed [31:0] query_point;
  } pche_in_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic [1:0]         status;
  } pche_out_t;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] mul_sel;
  } pche_cmd_t;

  typedef struct packed {
    logic range_hit;
    logic search_done;
    logic div_done;
    logic mul_done;
  } pche_stat_t;

endpackage

`default_nettype wire

### rtl/core/pche_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module pche_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/pche_mulq.sv
// Multi-cycle fixed-point multiplier: 64 x 16 bits a cycle, then rounding
// to nearest (ties away from zero) with magnitude clamped at 2^62. Uses pche_pkg.
`default_nettype none

module pche_mulq #(
  parameter int FRACTION_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic                    done,
  output logic signed [63:0]      p
);
  import pche_pkg::*;

  localparam logic [127:0] HALF  = 128'(1) << (FRACTION_BITS - 1);
  localparam logic [63:0]  SAT62 = 64'(1) << 62;

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_ROUND = 3'd5;

  logic [2:0]   phase;
  logic         neg;
  logic [63:0]  ma;
  logic [63:0]  mb;
  logic [127:0] acc;
  logic [79:0]  part;
  logic [127:0] rounded;
  logic [63:0]  mag;
  logic         ovf;

  // One partial product of the magnitude by the top digit of the multiplier.
  assign part    = ma * mb[63:48];
  assign rounded = acc + HALF;
  assign mag     = rounded[FRACTION_BITS +: 64];
  assign ovf     = (rounded[127:FRACTION_BITS+64] != '0) || (mag > SAT62);

  // Phase sequence: four digit steps, most significant first, then rounding.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        phase <= 3'd1;
      end else if (phase == PH_ROUND) begin
        phase <= PH_IDLE;
        done  <= 1'b1;
      end else if (phase != PH_IDLE) begin
        phase <= phase + 3'd1;
      end
    end
  end

  // Operand magnitudes, accumulator and the rounded, signed product.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= a[63] ^ b[63];
      ma  <= a[63] ? 64'(-a) : 64'(a);
      mb  <= b[63] ? 64'(-b) : 64'(b);
      acc <= '0;
    end else if (phase != PH_IDLE && phase != PH_ROUND) begin
      acc <= (acc << 16) + 128'(part);
      mb  <= mb << 16;
    end else if (phase == PH_ROUND) begin
      if (ovf) begin
        p <= neg ? -$signed(SAT62) : $signed(SAT62);
      end else begin
        p <= neg ? -$signed(mag) : $signed(mag);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/pche_dp.sv
// Datapath: knot tables, configuration, search bounds, theta divider,
// product registers and result register. Uses pche_pkg, pche_ram, pche_mulq.
`default_nettype none

module pche_dp #(
  parameter int MAX_KNOTS     = 256,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire pche_pkg::pche_cmd_t  cmd,
  output pche_pkg::pche_stat_t      stat,
  input  wire pche_pkg::pche_in_t   request,
  input  wire logic                 cfg_write,
  input  wire logic                 cfg_index,
  input  wire logic [8:0]           cfg_data,
  output logic                      valid,
  output pche_pkg::pche_out_t       response
);
  import pche_pkg::*;

  localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int KW = (AW + 1 > 9) ? AW + 1 : 9;
  localparam int F  = FRACTION_BITS;
  localparam int NW = 33 + F;
  localparam int CW = $clog2(F + 2);
  localparam logic [63:0] ONE = 64'(1) << F;

  // Configuration registers.
  logic [8:0] knot_count;
  logic       extrapolate;

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count  <= 9'd1;
      extrapolate <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == REG_KNOT_COUNT) begin
        knot_count <= cfg_data;
      end else begin
        extrapolate <= cfg_data[0];
      end
    end
  end

  // Knots in use, clipped to one and to the table depth.
  logic [KW-1:0] n_clip;
  logic [KW-1:0] n_minus1;
  logic [AW-1:0] last_idx;

  always_comb begin
    n_clip = KW'(knot_count);
    if (n_clip == '0) begin
      n_clip = KW'(1);
    end else if (n_clip > KW'(MAX_KNOTS)) begin
      n_clip = KW'(MAX_KNOTS);
    end
  end
  assign n_minus1 = n_clip - KW'(1);
  assign last_idx = n_minus1[AW-1:0];

  // Search bounds.
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  logic [AW:0]   mid_sum;
  logic [AW-1:0] mid;
  logic [AW:0]   gap;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[AW:1];
  assign gap     = {1'b0, hi} - {1'b0, lo};

  // Table write and read addressing.
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic signed [31:0] loc_rd;
  logic signed [31:0] val_rd;
  logic signed [31:0] slp_rd;

  assign we    = (cmd.op == CMD_WRITE) && (32'(request.entry_index) < 32'(MAX_KNOTS));
  assign waddr = AW'(request.entry_index);

  always_comb begin
    case (cmd.op)
      CMD_FIRST:   raddr = last_idx;
      CMD_SRCH_RD: raddr = mid;
      CMD_SEG0:    raddr = lo;
      CMD_SEG1:    raddr = lo + AW'(1);
      default:     raddr = '0;
    endcase
  end

  pche_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_loc (
    .clk(clk), .we(we), .waddr(waddr), .wdata(request.knot_position),
    .raddr(raddr), .rdata(loc_rd)
  );
  pche_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_val (
    .clk(clk), .we(we), .waddr(waddr), .wdata(request.knot_value),
    .raddr(raddr), .rdata(val_rd)
  );
  pche_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_slp (
    .clk(clk), .we(we), .waddr(waddr), .wdata(request.knot_slope),
    .raddr(raddr), .rdata(slp_rd)
  );

  // Query, end knots and segment knots.
  logic signed [31:0] x;
  logic signed [31:0] x_first;
  logic signed [31:0] y_first;
  logic signed [31:0] x_last;
  logic signed [31:0] y_last;
  logic signed [31:0] xl;
  logic signed [31:0] yl;
  logic signed [31:0] sl;
  logic signed [31:0] yh;
  logic signed [31:0] sh;
  logic [31:0]        d;
  logic [31:0]        h;
  logic [32:0]        d_full;
  logic [32:0]        h_full;
  logic               first_hit;
  logic               last_hit;

  assign first_hit = (x <= x_first);
  assign last_hit  = (x >= x_last);
  assign d_full    = {x[31], x} - {xl[31], xl};
  assign h_full    = {loc_rd[31], loc_rd} - {xl[31], xl};

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        x <= request.query_point;
      end
      CMD_FIRST: begin
        x_first <= loc_rd;
        y_first <= val_rd;
      end
      CMD_LAST: begin
        x_last <= loc_rd;
        y_last <= val_rd;
      end
      CMD_SEG1: begin
        xl <= loc_rd;
        yl <= val_rd;
        sl <= slp_rd;
      end
      CMD_SEG2: begin
        yh <= val_rd;
        sh <= slp_rd;
        d  <= d_full[31:0];
        h  <= h_full[31:0];
      end
      default: begin
      end
    endcase
  end

  // Search bound updates.
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_CHECK) begin
      lo <= '0;
      hi <= last_idx;
    end else if (cmd.op == CMD_CMP) begin
      if (x < loc_rd) begin
        hi <= mid;
      end else begin
        lo <= mid;
      end
    end
  end

  // Restoring divider for theta = (d * 2^F + h/2) / h, one quotient bit a cycle.
  logic [NW-1:0] num;
  logic [31:0]   rem;
  logic [F:0]    nlow;
  logic [F:0]    theta;
  logic [CW-1:0] div_cnt;
  logic [32:0]   rem2;

  assign num  = {1'b0, d, {F{1'b0}}} + NW'(h >> 1);
  assign rem2 = {rem, nlow[F]};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.op == CMD_DIVI) begin
      div_cnt <= CW'(F + 1);
    end else if (cmd.op == CMD_DIV) begin
      div_cnt <= div_cnt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_DIVI) begin
      rem   <= num[NW-1:F+1];
      nlow  <= num[F:0];
      theta <= '0;
    end else if (cmd.op == CMD_DIV) begin
      nlow <= nlow << 1;
      if (rem2 >= {1'b0, h}) begin
        rem   <= 32'(rem2 - {1'b0, h});
        theta <= {theta[F-1:0], 1'b1};
      end else begin
        rem   <= rem2[31:0];
        theta <= {theta[F-1:0], 1'b0};
      end
    end
  end

  // Hermite terms feeding the shared multiplier.
  logic signed [63:0] t64;
  logic signed [63:0] a64;
  logic signed [63:0] g64;
  logic signed [63:0] prod [8];
  logic signed [63:0] op_a;
  logic signed [63:0] op_b;
  logic signed [63:0] mul_p;
  logic               mul_done;

  assign t64 = $signed(64'(theta));
  assign a64 = $signed(ONE) - t64;
  assign g64 = (t64 <<< 1) - $signed(ONE);

  // Product order: beta, alpha*y0, theta*y1, alpha*s0, theta*s1,
  // gamma*(y1-y0), h*(alpha*s0 - theta*s1), beta*inner.
  always_comb begin
    case (cmd.mul_sel)
      3'd0: begin op_a = t64; op_b = a64; end
      3'd1: begin op_a = a64; op_b = 64'(yl); end
      3'd2: begin op_a = t64; op_b = 64'(yh); end
      3'd3: begin op_a = a64; op_b = 64'(sl); end
      3'd4: begin op_a = t64; op_b = 64'(sh); end
      3'd5: begin op_a = g64; op_b = 64'(yh) - 64'(yl); end
      3'd6: begin op_a = $signed(64'(h)); op_b = prod[3] - prod[4]; end
      default: begin op_a = prod[0]; op_b = prod[5] + prod[6]; end
    endcase
  end

  pche_mulq #(.FRACTION_BITS(F)) u_mulq (
    .clk(clk), .rst(rst), .start(cmd.op == CMD_MUL_GO),
    .a(op_a), .b(op_b), .done(mul_done), .p(mul_p)
  );

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_MUL_TAKE) begin
      prod[cmd.mul_sel] <= mul_p;
    end
  end

  // Final sum with saturation to 32 bits.
  logic signed [63:0] v;
  assign v = prod[1] + prod[2] + prod[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= (cmd.op == CMD_FIN) || ((cmd.op == CMD_CHECK) && (first_hit || last_hit));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_FIN) begin
      if (v > 64'sd2147483647) begin
        response.result <= 32'sh7fffffff;
        response.status <= ST_SAT;
      end else if (v < -64'sd2147483648) begin
        response.result <= 32'sh80000000;
        response.status <= ST_SAT;
      end else begin
        response.result <= v[31:0];
        response.status <= ST_OK;
      end
    end else if (cmd.op == CMD_CHECK) begin
      if (first_hit) begin
        response.result <= extrapolate ? y_first : 32'sd0;
        response.status <= extrapolate ? ST_OK : ST_BELOW;
      end else begin
        response.result <= extrapolate ? y_last : 32'sd0;
        response.status <= extrapolate ? ST_OK : ST_ABOVE;
      end
    end
  end

  assign stat.range_hit   = first_hit || last_hit;
  assign stat.search_done = (gap <= (AW+1)'(1));
  assign stat.div_done    = (div_cnt == '0);
  assign stat.mul_done    = mul_done;

endmodule

`default_nettype wire

### rtl/core/pche_ctrl.sv
// Controller state machine: sequences table reads, search, divide and
// products by issuing commands to the datapath. Uses pche_pkg.
`default_nettype none

module pche_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic                 opcode,
  input  wire pche_pkg::pche_stat_t stat,
  output pche_pkg::pche_cmd_t       cmd,
  output logic                      busy
);
  import pche_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIRST = 4'd1;
  localparam logic [3:0] S_LAST  = 4'd2;
  localparam logic [3:0] S_CHECK = 4'd3;
  localparam logic [3:0] S_SRCH  = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_SEG1  = 4'd6;
  localparam logic [3:0] S_SEG2  = 4'd7;
  localparam logic [3:0] S_DIVI  = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_MULS  = 4'd10;
  localparam logic [3:0] S_MULW  = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [2:0] mul_sel;
  logic [2:0] mul_sel_next;

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    mul_sel_next = mul_sel;
    cmd.op       = CMD_NONE;
    cmd.mul_sel  = mul_sel;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (opcode == OP_WRITE) begin
            cmd.op = CMD_WRITE;
          end else begin
            cmd.op     = CMD_LOAD;
            state_next = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        cmd.op     = CMD_FIRST;
        state_next = S_LAST;
      end
      S_LAST: begin
        cmd.op     = CMD_LAST;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.op     = CMD_CHECK;
        state_next = stat.range_hit ? S_IDLE : S_SRCH;
      end
      S_SRCH: begin
        if (stat.search_done) begin
          cmd.op     = CMD_SEG0;
          state_next = S_SEG1;
        end else begin
          cmd.op     = CMD_SRCH_RD;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.op     = CMD_CMP;
        state_next = S_SRCH;
      end
      S_SEG1: begin
        cmd.op     = CMD_SEG1;
        state_next = S_SEG2;
      end
      S_SEG2: begin
        cmd.op     = CMD_SEG2;
        state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.op     = CMD_DIVI;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          mul_sel_next = '0;
          state_next   = S_MULS;
        end else begin
          cmd.op = CMD_DIV;
        end
      end
      S_MULS: begin
        cmd.op     = CMD_MUL_GO;
        state_next = S_MULW;
      end
      S_MULW: begin
        if (stat.mul_done) begin
          cmd.op = CMD_MUL_TAKE;
          if (mul_sel == MUL_LAST) begin
            state_next = S_FIN;
          end else begin
            mul_sel_next = mul_sel + 3'd1;
            state_next   = S_MULS;
          end
        end
      end
      S_FIN: begin
        cmd.op     = CMD_FIN;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mul_sel <= '0;
    end else begin
      state   <= state_next;
      mul_sel <= mul_sel_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/piecewise_cubic_hermite_eval_core.sv
// Top level of the piecewise cubic Hermite evaluator.
// Uses pche_pkg, pche_ctrl and pche_dp (which holds pche_ram and pche_mulq).
`default_nettype none

// A beat is taken when start is high and busy is low. A write beat stores
// one knot and leaves busy low. An evaluate beat returns one result, flagged
// by valid for exactly one cycle; the receiver cannot stall it, so it must
// take the result in that cycle. An evaluation outside the knot range keeps
// busy high through the first-knot, last-knot and range-check states, and
// valid rises as busy falls. Inside the range busy stays high through the
// binary search, where each step reads the registered table and then
// compares, the theta divider, which yields one quotient bit a cycle, and
// the eight products, which share one multiplier, each with its start and
// its take.
// Configuration is written through cfg_write; the user must do so only
// while idle, as the block itself does not enforce it.
module piecewise_cubic_hermite_eval_core #(
  parameter int MAX_KNOTS     = pche_pkg::MAX_KNOTS_DEF,
  parameter int FRACTION_BITS = pche_pkg::FRACTION_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire pche_pkg::pche_in_t request,
  output logic                    busy,
  output logic                    valid,
  output pche_pkg::pche_out_t     response,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic [8:0]         cfg_data
);
  import pche_pkg::*;

  pche_cmd_t  cmd;
  pche_stat_t stat;

  // Controller.
  pche_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .opcode(request.opcode),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  // Datapath.
  pche_dp #(.MAX_KNOTS(MAX_KNOTS), .FRACTION_BITS(FRACTION_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .request(request),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .valid(valid), .response(response)
  );

endmodule

`default_nettype wire

### verif/testbench.sv
// Testbench for piecewise_cubic_hermite_eval_core: knot writes, evaluations and register settings.
// Depends on pche_pkg and the core; the scoreboard class predicts each result.
`timescale 1ns / 1ps

class hermite_scoreboard;
  logic signed [31:0] loc_tab [256];
  logic signed [31:0] val_tab [256];
  logic signed [31:0] slp_tab [256];
  logic [8:0] knots;
  logic       extrap;
  pche_pkg::pche_out_t pending [$];
  int errors;
  int evals;

  function new();
    knots = 9'd1;
    extrap = 1'b0;
    errors = 0;
    evals = 0;
    for (int i = 0; i < 256; i++) begin
      loc_tab[i] = '0;
      val_tab[i] = '0;
      slp_tab[i] = '0;
    end
  endfunction

  // Fixed-point product rounded half away from zero, magnitude clamped at 2^62.
  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] ua, ub, p, r;
    logic neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    p = ua * ub;
    r = (p + 128'd32768) >> 16;
    if (r > (128'd1 << 62)) r = 128'd1 << 62;
    return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  function void note_config(logic idx, logic [8:0] data);
    if (idx == pche_pkg::REG_KNOT_COUNT) knots = data;
    else extrap = data[0];
  endfunction

  // Records one accepted beat; evaluations queue their expected result.
  function void note_beat(pche_pkg::pche_in_t b);
    int n, lo, hi, mid;
    longint x, span, t, a, one, beta, gamma, term1, m, inner, v;
    longint unsigned d;
    pche_pkg::pche_out_t exp_out;
    if (b.opcode == pche_pkg::OP_WRITE) begin
      loc_tab[b.entry_index] = b.knot_position;
      val_tab[b.entry_index] = b.knot_value;
      slp_tab[b.entry_index] = b.knot_slope;
      return;
    end
    n = (knots == 0) ? 1 : ((knots > 256) ? 256 : knots);
    x = b.query_point;
    exp_out.status = pche_pkg::ST_OK;
    if (x <= loc_tab[0]) begin
      v = extrap ? val_tab[0] : 0;
      if (!extrap) exp_out.status = pche_pkg::ST_BELOW;
    end else if (x >= loc_tab[n-1]) begin
      v = extrap ? val_tab[n-1] : 0;
      if (!extrap) exp_out.status = pche_pkg::ST_ABOVE;
    end else begin
      lo = 0;
      hi = n - 1;
      while (hi - lo > 1) begin
        mid = (lo + hi) / 2;
        if (x < loc_tab[mid]) hi = mid;
        else lo = mid;
      end
      span = longint'(loc_tab[lo+1]) - longint'(loc_tab[lo]);
      d = x - longint'(loc_tab[lo]);
      t = ((d << 16) + (span >> 1)) / span;
      one = 64'sd65536;
      a = one - t;
      beta = fx_mul(t, a);
      gamma = 2 * t - one;
      term1 = fx_mul(a, val_tab[lo]) + fx_mul(t, val_tab[lo+1]);
      m = fx_mul(a, slp_tab[lo]) - fx_mul(t, slp_tab[lo+1]);
      inner = fx_mul(gamma, longint'(val_tab[lo+1]) - longint'(val_tab[lo])) + fx_mul(span, m);
      v = term1 + fx_mul(beta, inner);
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        exp_out.status = pche_pkg::ST_SAT;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        exp_out.status = pche_pkg::ST_SAT;
      end
    end
    exp_out.result = v[31:0];
    pending.push_back(exp_out);
  endfunction

  // Compares one result beat with the oldest expectation.
  function void check_result(pche_pkg::pche_out_t got);
    pche_pkg::pche_out_t e;
    evals++;
    if (pending.size() == 0) begin
      $error("unexpected result %h status %0d", got.result, got.status);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.result !== e.result) begin
      $error("result: expected %h, actual %h", e.result, got.result);
      errors++;
    end
    if (got.status !== e.status) begin
      $error("status: expected %0d, actual %0d", e.status, got.status);
      errors++;
    end
  endfunction
endclass

module testbench;
  import pche_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  pche_in_t request = '0;
  logic busy, valid;
  pche_out_t response;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [8:0] cfg_data = '0;

  hermite_scoreboard board = new();
  int idle_cycles = 0;
  int writes_done = 0;
  int evals_sent = 0;
  logic signed [31:0] knot_loc [256];
  int table_size = 1;

  piecewise_cubic_hermite_eval_core uut (
    .clk(clk), .rst(rst), .start(start), .request(request), .busy(busy),
    .valid(valid), .response(response), .cfg_write(cfg_write),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result monitor and beat bookkeeping, sampled at the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (valid) board.check_result(response);
      if (start && !busy) board.note_beat(request);
      if (valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles with no beat in either direction.
  always @(posedge clk) begin
    if (idle_cycles > 20000) begin
      $display("watchdog expired");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Presents one beat and holds it until accepted. Start stays high so that
  // a following beat can go out back to back; drain or a gap lowers it.
  task automatic send_beat(pche_in_t b);
    start <= 1'b1;
    request <= b;
    do @(posedge clk); while (busy);
    if (b.opcode == OP_WRITE) writes_done++;
    else evals_sent++;
  endtask

  task automatic write_knot(int idx, logic [31:0] p, logic [31:0] v, logic [31:0] s);
    pche_in_t b;
    b = '0;
    b.opcode = OP_WRITE;
    b.entry_index = idx[7:0];
    b.knot_position = p;
    b.knot_value = v;
    b.knot_slope = s;
    b.query_point = $urandom();
    knot_loc[idx] = p;
    send_beat(b);
  endtask

  task automatic eval_at(logic [31:0] x);
    pche_in_t b;
    b = '0;
    b.opcode = OP_EVAL;
    b.entry_index = $urandom();
    b.knot_position = $urandom();
    b.knot_value = $urandom();
    b.knot_slope = $urandom();
    b.query_point = x;
    send_beat(b);
  endtask

  // Waits for every expected result, plus a tail, before touching registers.
  task automatic drain();
    int guard;
    start <= 1'b0;
    guard = 0;
    while (board.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (120) @(posedge clk);
  endtask

  task automatic set_reg(logic idx, logic [8:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.note_config(idx, data);
    @(posedge clk);
  endtask

  // Fills slots 0..n-1 with sorted locations and random values and slopes, or all random when wild.
  task automatic build_table(int n, int step_max, bit wild);
    logic signed [31:0] p;
    p = -$signed(32'($urandom_range(1 << 20, 0)));
    for (int i = 0; i < n; i++) begin
      if (wild) write_knot(i, $urandom(), $urandom(), $urandom());
      else write_knot(i, p, $urandom() >> $urandom_range(16, 0),
                      $urandom() >> $urandom_range(20, 2));
      p = p + 32'($urandom_range(step_max, 1));
    end
    table_size = n;
  endtask

  function automatic logic [31:0] pick_query(int n);
    int i;
    i = $urandom_range(n - 1, 0);
    case ($urandom_range(9, 0))
      0: return $urandom();
      1: return knot_loc[i];
      2: return knot_loc[0] - 32'($urandom_range(100, 0));
      3: return knot_loc[n-1] + 32'($urandom_range(100, 0));
      default: begin
        if (i == n - 1) return knot_loc[i] - 1;
        return knot_loc[i] + 32'($urandom_range(32'(knot_loc[i+1] - knot_loc[i]), 0));
      end
    endcase
  endfunction

  initial begin
    int burst, n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single knot with reset registers, both sides out of range.
    write_knot(0, 32'sh0001_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
    eval_at(32'sh0001_0000);
    eval_at(32'sh7FFF_FFFF);
    eval_at(32'sh8000_0000);
    drain();
    set_reg(REG_EXTRAPOLATE, 9'd1);
    set_reg(REG_KNOT_COUNT, 9'd0);
    eval_at(32'sh8000_0000);
    eval_at(32'sh7FFF_FFFF);
    drain();
    // Extreme values and slopes force saturation inside a wide segment.
    write_knot(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
    write_knot(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    write_knot(255, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    knot_loc[255] = 32'sh7FFF_FFFF;
    drain();
    set_reg(REG_KNOT_COUNT, 9'd2);
    eval_at(32'sh0000_0000);
    eval_at(32'sh8000_0001);
    eval_at(32'sh7FFF_FFFE);
    eval_at(32'shC000_0000);
    drain();
    set_reg(REG_EXTRAPOLATE, 9'd0);
    set_reg(REG_KNOT_COUNT, 9'h1FF);
    eval_at(32'sh7FFF_FFFF);
    drain();

    // Random phases: rebuild the table, pick registers, then query in bursts with rare writes to unused slots.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: n = $urandom_range(4, 2);
        1: n = $urandom_range(16, 2);
        2: n = 256;
        default: n = $urandom_range(64, 2);
      endcase
      build_table(n, (ph % 3 == 0) ? 32'h0100_0000 : 32'h0002_0000, ph == 5 || ph == 7);
      drain();
      set_reg(REG_KNOT_COUNT, (ph == 3) ? 9'h1FF : 9'(n));
      set_reg(REG_EXTRAPOLATE, 9'($urandom_range(1, 0)));
      for (int k = 0; k < 32; k++) begin
        burst = $urandom_range(6, 1);
        repeat (burst) begin
          if (n < 256 && $urandom_range(15, 0) == 0)
            write_knot($urandom_range(255, n), $urandom(), $urandom(), $urandom());
          else
            eval_at(pick_query(n));
        end
        if ($urandom_range(3, 0) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(150, 1)) @(posedge clk);
        end
      end
      // Hold off once per phase until everything has come back.
      drain();
    end

    drain();
    $display("Covered %0d knot writes and %0d evaluations, %0d results checked.",
             writes_done, evals_sent, board.evals);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
